/* rtl/core/ssc_pkg.sv */
package ssc_pkg;

    localparam int MODE_W = 4;

    localparam logic [MODE_W-1:0] MODE_NONE            = 4'd0;
    localparam logic [MODE_W-1:0] MODE_FILL            = 4'd1;
    localparam logic [MODE_W-1:0] MODE_UNIFORM         = 4'd2;
    localparam logic [MODE_W-1:0] MODE_UNIFORM_TO_FILL = 4'd3;
    localparam logic [MODE_W-1:0] MODE_FILL_WIDTH      = 4'd4;
    localparam logic [MODE_W-1:0] MODE_FILL_HEIGHT     = 4'd5;
    localparam logic [MODE_W-1:0] MODE_PERCENT         = 4'd6;
    localparam logic [MODE_W-1:0] MODE_EXPAND_WIDTH    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_EXPAND_HEIGHT   = 4'd8;

    // internal operation after the expand modes are resolved
    localparam int OP_W = 3;

    localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
    localparam logic [OP_W-1:0] OP_FILL    = 3'd1;
    localparam logic [OP_W-1:0] OP_UNIFORM = 3'd2;
    localparam logic [OP_W-1:0] OP_UTF     = 3'd3;
    localparam logic [OP_W-1:0] OP_FILL_W  = 3'd4;
    localparam logic [OP_W-1:0] OP_FILL_H  = 3'd5;
    localparam logic [OP_W-1:0] OP_PERCENT = 3'd6;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

/* rtl/core/stretch_scale_calculator.sv */
// Stretch scale calculator.
// Slave stream (s_*): one beat per layout request; mode, source size, target
// size and percent factors packed in s_tdata. Master stream (m_*): one beat per
// request with x/y scale and resulting size, in request order.
// Sizes carry 8 fraction bits, scales SCALE_FRAC_BITS fraction bits; every
// quotient and product is truncated and saturated at 2^SIZE_BITS - 1.
// Front: input register and the percent multipliers, then a 4-entry queue.
// Back: two restoring dividers (one quotient bit per stage, SIZE_BITS + 1
// stages), scale select, apply multipliers, output register.
// Throughput: one beat per cycle while m_tready stays high.
// Reset clears all valid flags and the queue pointers; nothing is pending.
// When m_tready is low with an output beat held, the back pipe freezes in place;
// the queue absorbs what the front still has in flight, and s_tready falls once the queue fills.
module stretch_scale_calculator #(
    parameter int SIZE_BITS       = 24,
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // mode[3:0], self_width, self_height, target_width, target_height,
    // percent_x, percent_y (SIZE_BITS each), zero pad to bytes
    input  logic [((4+6*SIZE_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // scale_x, scale_y, result_width, result_height (SIZE_BITS each), zero pad
    output logic [((4*SIZE_BITS+7)/8)*8-1:0] m_tdata
);
    import ssc_pkg::*;

    localparam int W      = SIZE_BITS;
    localparam int OUT_DW = ((4*SIZE_BITS+7)/8)*8;
    localparam int QDW    = OP_W + 4 * W;

    logic            push, pop;
    logic [QDW-1:0]  q_in, q_out;
    q_stat_t         q_stat;
    logic [W-1:0]    scale_x, scale_y, result_width, result_height;

    ssc_front #(.W(W), .F(SCALE_FRAC_BITS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .mode          (s_tdata[MODE_W-1:0]),
        .self_width    (s_tdata[MODE_W       +: W]),
        .self_height   (s_tdata[MODE_W + W   +: W]),
        .target_width  (s_tdata[MODE_W + 2*W +: W]),
        .target_height (s_tdata[MODE_W + 3*W +: W]),
        .percent_x     (s_tdata[MODE_W + 4*W +: W]),
        .percent_y     (s_tdata[MODE_W + 5*W +: W]),
        .q_stat        (q_stat),
        .push          (push),
        .q_data        (q_in)
    );

    ssc_queue #(.DW(QDW), .DEPTH(4)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_in),
        .pop   (pop),
        .rdata (q_out),
        .stat  (q_stat)
    );

    ssc_back #(.W(W), .F(SCALE_FRAC_BITS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (q_out),
        .q_stat        (q_stat),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .scale_x       (scale_x),
        .scale_y       (scale_y),
        .result_width  (result_width),
        .result_height (result_height)
    );

    assign m_tdata = OUT_DW'({result_height, result_width, scale_y, scale_x});

    // queue is never written when full nor read when empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue read while empty");

    // a full queue is never drained without a read
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.full && !pop) |=> !q_stat.empty)
        else $error("queue drained without a read");

endmodule

/* rtl/core/ssc_div.sv */
module ssc_div #(
    parameter int W = 24,
    parameter int F = 16
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic [W-1:0] quo
);
    // floor(num * 2^F / den), saturated, zero for a zero den; one quotient bit per stage
    localparam int RW = 2 * W + F;

    logic [RW-1:0] r_reg   [0:W];
    logic [W-1:0]  d_reg   [0:W];
    logic [W-1:0]  q_reg   [0:W];
    logic          ovf_reg [0:W];
    logic          zero_reg[0:W];

    logic [RW-1:0] dividend;

    assign dividend = RW'(num) << F;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= dividend;
            d_reg[0]    <= den;
            q_reg[0]    <= '0;
            zero_reg[0] <= (den == '0);
            ovf_reg[0]  <= (dividend >= (RW'(den) << W));
        end
    end

    for (genvar i = 1; i <= W; i++)
    begin : g_stage
        localparam int B = W - i;
        logic [RW-1:0] sub;
        logic          ge;

        assign sub = RW'(d_reg[i-1]) << B;
        assign ge  = (r_reg[i-1] >= sub);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i]    <= ge ? (r_reg[i-1] - sub) : r_reg[i-1];
                d_reg[i]    <= d_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
                ovf_reg[i]  <= ovf_reg[i-1];
                q_reg[i]    <= q_reg[i-1] | (ge ? (W'(1) << B) : '0);
            end
        end
    end

    assign quo = zero_reg[W] ? '0 : (ovf_reg[W] ? '1 : q_reg[W]);

endmodule

/* rtl/core/ssc_queue.sv */
module ssc_queue #(
    parameter int DW    = 100,
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [DW-1:0]   wdata,
    input  logic            pop,
    output logic [DW-1:0]   rdata,
    output ssc_pkg::q_stat_t stat
);
    import ssc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DW-1:0] mem [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign stat.full  = (count_reg == (AW+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= inc_ptr(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= inc_ptr(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/ssc_front.sv */
module ssc_front #(
    parameter int W = 24,
    parameter int F = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ssc_pkg::MODE_W-1:0]    mode,
    input  logic [W-1:0]                  self_width,
    input  logic [W-1:0]                  self_height,
    input  logic [W-1:0]                  target_width,
    input  logic [W-1:0]                  target_height,
    input  logic [W-1:0]                  percent_x,
    input  logic [W-1:0]                  percent_y,
    input  ssc_pkg::q_stat_t              q_stat,
    output logic                          push,
    output logic [ssc_pkg::OP_W+4*W-1:0]  q_data
);
    import ssc_pkg::*;

    logic [OP_W-1:0] op_next;

    logic            f1_valid_reg;
    logic [OP_W-1:0] f1_op_reg;
    logic [W-1:0]    f1_sw_reg, f1_sh_reg, f1_tw_reg, f1_th_reg, f1_px_reg, f1_py_reg;

    logic            f2_valid_reg;
    logic [OP_W-1:0] f2_op_reg;
    logic [W-1:0]    f2_sw_reg, f2_sh_reg, f2_tw_reg, f2_th_reg;
    logic [2*W-1:0]  f2_pw_reg, f2_ph_reg;

    logic            f1_ready, f2_ready;
    logic [2*W-1:0]  pw_shift, ph_shift;
    logic [W-1:0]    pw_sat, ph_sat, nx, ny;

    always_comb
    begin
        unique case (mode)
            MODE_FILL:            op_next = OP_FILL;
            MODE_UNIFORM:         op_next = OP_UNIFORM;
            MODE_UNIFORM_TO_FILL: op_next = OP_UTF;
            MODE_FILL_WIDTH:      op_next = OP_FILL_W;
            MODE_FILL_HEIGHT:     op_next = OP_FILL_H;
            MODE_PERCENT:         op_next = OP_PERCENT;
            MODE_EXPAND_WIDTH:
                op_next = (target_width > self_width) ? OP_FILL_W : OP_NONE;
            MODE_EXPAND_HEIGHT:
                op_next = (target_height > self_height) ? OP_FILL_H : OP_NONE;
            default:              op_next = OP_NONE;
        endcase
    end

    assign f2_ready = !f2_valid_reg || !q_stat.full;
    assign f1_ready = !f1_valid_reg || f2_ready;
    assign in_ready = f1_ready;
    assign push     = f2_valid_reg && !q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            if (f1_ready)
            begin
                f1_valid_reg <= in_valid;
            end
            if (f2_ready)
            begin
                f2_valid_reg <= f1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_ready && in_valid)
        begin
            f1_op_reg <= op_next;
            f1_sw_reg <= self_width;
            f1_sh_reg <= self_height;
            f1_tw_reg <= target_width;
            f1_th_reg <= target_height;
            f1_px_reg <= percent_x;
            f1_py_reg <= percent_y;
        end
        if (f2_ready && f1_valid_reg)
        begin
            f2_op_reg <= f1_op_reg;
            f2_sw_reg <= f1_sw_reg;
            f2_sh_reg <= f1_sh_reg;
            f2_tw_reg <= f1_tw_reg;
            f2_th_reg <= f1_th_reg;
            f2_pw_reg <= (2*W)'(f1_tw_reg) * (2*W)'(f1_px_reg);
            f2_ph_reg <= (2*W)'(f1_th_reg) * (2*W)'(f1_py_reg);
        end
    end

    // percent size: drop scale fraction, saturate
    assign pw_shift = f2_pw_reg >> F;
    assign ph_shift = f2_ph_reg >> F;
    assign pw_sat   = (|pw_shift[2*W-1:W]) ? '1 : pw_shift[W-1:0];
    assign ph_sat   = (|ph_shift[2*W-1:W]) ? '1 : ph_shift[W-1:0];

    assign nx = (f2_op_reg == OP_PERCENT) ? pw_sat : f2_tw_reg;
    assign ny = (f2_op_reg == OP_PERCENT) ? ph_sat : f2_th_reg;

    assign q_data = {f2_op_reg, f2_sw_reg, f2_sh_reg, nx, ny};

endmodule

/* rtl/core/ssc_back.sv */
module ssc_back #(
    parameter int W = 24,
    parameter int F = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ssc_pkg::OP_W+4*W-1:0]  q_data,
    input  ssc_pkg::q_stat_t              q_stat,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [W-1:0]                  scale_x,
    output logic [W-1:0]                  scale_y,
    output logic [W-1:0]                  result_width,
    output logic [W-1:0]                  result_height
);
    import ssc_pkg::*;

    localparam int L = W + 1;
    localparam logic [W-1:0] ONE_K = (F < W) ? (W'(1) << F) : {W{1'b1}};

    logic            en;
    logic [OP_W-1:0] h_op;
    logic [W-1:0]    h_sw, h_sh, h_nx, h_ny;
    logic [W-1:0]    qx, qy;

    logic            sb_valid_reg [0:L-1];
    logic [OP_W-1:0] sb_op_reg    [0:L-1];
    logic [W-1:0]    sb_sw_reg    [0:L-1];
    logic [W-1:0]    sb_sh_reg    [0:L-1];
    logic [W-1:0]    sb_nx_reg    [0:L-1];
    logic [W-1:0]    sb_ny_reg    [0:L-1];

    logic            a_valid_reg, a_mw_reg, a_mh_reg;
    logic [W-1:0]    a_kx_reg, a_ky_reg, a_bw_reg, a_bh_reg, a_sw_reg, a_sh_reg;
    logic            a_mw_next, a_mh_next;
    logic [W-1:0]    a_kx_next, a_ky_next, a_bw_next, a_bh_next;

    logic            b_valid_reg, b_mw_reg, b_mh_reg;
    logic [W-1:0]    b_kx_reg, b_ky_reg, b_bw_reg, b_bh_reg;
    logic [2*W-1:0]  b_pw_reg, b_ph_reg;

    logic            o_valid_reg;
    logic [W-1:0]    o_kx_reg, o_ky_reg, o_rw_reg, o_rh_reg;
    logic [2*W-1:0]  pw_shift, ph_shift;
    logic [W-1:0]    pw_sat, ph_sat;

    assign {h_op, h_sw, h_sh, h_nx, h_ny} = q_data;

    // whole back pipe moves together when the output slot is free or drains
    assign en  = !o_valid_reg || out_ready;
    assign pop = en && !q_stat.empty;

    ssc_div #(.W(W), .F(F)) u_div_x (
        .clk (clk),
        .en  (en),
        .num (h_nx),
        .den (h_sw),
        .quo (qx)
    );

    ssc_div #(.W(W), .F(F)) u_div_y (
        .clk (clk),
        .en  (en),
        .num (h_ny),
        .den (h_sh),
        .quo (qy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L; i++)
            begin
                sb_valid_reg[i] <= 1'b0;
            end
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sb_valid_reg[0] <= !q_stat.empty;
            for (int i = 1; i < L; i++)
            begin
                sb_valid_reg[i] <= sb_valid_reg[i-1];
            end
            a_valid_reg <= sb_valid_reg[L-1];
            b_valid_reg <= a_valid_reg;
            o_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_op_reg[0] <= h_op;
            sb_sw_reg[0] <= h_sw;
            sb_sh_reg[0] <= h_sh;
            sb_nx_reg[0] <= h_nx;
            sb_ny_reg[0] <= h_ny;
            for (int i = 1; i < L; i++)
            begin
                sb_op_reg[i] <= sb_op_reg[i-1];
                sb_sw_reg[i] <= sb_sw_reg[i-1];
                sb_sh_reg[i] <= sb_sh_reg[i-1];
                sb_nx_reg[i] <= sb_nx_reg[i-1];
                sb_ny_reg[i] <= sb_ny_reg[i-1];
            end
        end
    end

    // scale selection per operation
    always_comb
    begin
        a_kx_next = ONE_K;
        a_ky_next = ONE_K;
        a_bw_next = sb_sw_reg[L-1];
        a_bh_next = sb_sh_reg[L-1];
        a_mw_next = 1'b0;
        a_mh_next = 1'b0;
        case (sb_op_reg[L-1])
            OP_FILL, OP_PERCENT:
            begin
                a_kx_next = qx;
                a_ky_next = qy;
                a_bw_next = sb_nx_reg[L-1];
                a_bh_next = sb_ny_reg[L-1];
            end
            OP_UNIFORM:
            begin
                a_kx_next = (qx < qy) ? qx : qy;
                a_ky_next = a_kx_next;
                a_mw_next = 1'b1;
                a_mh_next = 1'b1;
            end
            OP_UTF:
            begin
                a_kx_next = (qx > qy) ? qx : qy;
                a_ky_next = a_kx_next;
                a_mw_next = 1'b1;
                a_mh_next = 1'b1;
            end
            OP_FILL_W:
            begin
                a_kx_next = qx;
                a_ky_next = qx;
                a_bw_next = sb_nx_reg[L-1];
                a_mh_next = 1'b1;
            end
            OP_FILL_H:
            begin
                a_kx_next = qy;
                a_ky_next = qy;
                a_bh_next = sb_ny_reg[L-1];
                a_mw_next = 1'b1;
            end
            default:
            begin
                a_kx_next = ONE_K;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_kx_reg <= a_kx_next;
            a_ky_reg <= a_ky_next;
            a_bw_reg <= a_bw_next;
            a_bh_reg <= a_bh_next;
            a_mw_reg <= a_mw_next;
            a_mh_reg <= a_mh_next;
            a_sw_reg <= sb_sw_reg[L-1];
            a_sh_reg <= sb_sh_reg[L-1];

            b_pw_reg <= (2*W)'(a_sw_reg) * (2*W)'(a_kx_reg);
            b_ph_reg <= (2*W)'(a_sh_reg) * (2*W)'(a_ky_reg);
            b_kx_reg <= a_kx_reg;
            b_ky_reg <= a_ky_reg;
            b_bw_reg <= a_bw_reg;
            b_bh_reg <= a_bh_reg;
            b_mw_reg <= a_mw_reg;
            b_mh_reg <= a_mh_reg;

            o_kx_reg <= b_kx_reg;
            o_ky_reg <= b_ky_reg;
            o_rw_reg <= b_mw_reg ? pw_sat : b_bw_reg;
            o_rh_reg <= b_mh_reg ? ph_sat : b_bh_reg;
        end
    end

    assign pw_shift = b_pw_reg >> F;
    assign ph_shift = b_ph_reg >> F;
    assign pw_sat   = (|pw_shift[2*W-1:W]) ? '1 : pw_shift[W-1:0];
    assign ph_sat   = (|ph_shift[2*W-1:W]) ? '1 : ph_shift[W-1:0];

    assign out_valid     = o_valid_reg;
    assign scale_x       = o_kx_reg;
    assign scale_y       = o_ky_reg;
    assign result_width  = o_rw_reg;
    assign result_height = o_rh_reg;

endmodule
